[rtl/chi_pkg.sv]
// Shared constants, widths and the saturation helper for the cubic Hermite interpolator.
// No dependencies.
`default_nettype none
package chi_pkg;

  // Field widths
  localparam int DATA_W = 32;             // signed Q16.16 fields
  localparam int TIME_W = 31;             // unsigned Q15.16 time fields
  localparam int FRAC_W = 30;             // Q1.30 normalized time
  localparam int U_W    = FRAC_W + 1;     // u spans 0..2^30
  localparam int SUM_W  = 53;             // wide accumulation width before saturation

  // Normalized time divider: (tc << 30) / T
  localparam int NDIV_NUM_W = TIME_W + FRAC_W;
  localparam int NDIV_DEN_W = TIME_W;
  localparam int NDIV_QUO_W = U_W;

  // Velocity slope divider: |k * (P1 - P0)| / (T << 14)
  localparam int VDIV_NUM_W = 63;
  localparam int VDIV_DEN_W = TIME_W + 14;
  localparam int VDIV_QUO_W = 50;

  localparam logic signed [33:0] ONE_Q30 = 34'sd1 << FRAC_W;

  // Clip a wide signed value to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(33'sh0_7FFF_FFFF);
    lo = -hi - SUM_W'(1);
    if (x > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = x[DATA_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

[rtl/chi_pipe_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a sideband that travels along.
// Uses no package items; quotient must be known to fit in QW bits.
`default_nettype none
module chi_pipe_div #(
  parameter int NW = 61,
  parameter int DW = 31,
  parameter int QW = 31,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [QW-1:0]      out_quo,
  output logic               out_rem_nz,
  output logic [SW-1:0]      out_side
);

  logic [QW-1:0] v_r;
  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] nq_r   [QW];
  logic [DW-1:0] den_r  [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic          v_i;
    logic [DW-1:0] rem_i;
    logic [QW-1:0] nq_i;
    logic [DW-1:0] den_i;
    logic [SW-1:0] side_i;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    // Pick up the previous stage, or the operands at the first stage
    if (s == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = DW'(in_num >> QW);
      assign nq_i   = in_num[QW-1:0];
      assign den_i  = in_den;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[s-1];
      assign rem_i  = rem_r[s-1];
      assign nq_i   = nq_r[s-1];
      assign den_i  = den_r[s-1];
      assign side_i = side_r[s-1];
    end

    // Shift in the next numerator bit and try a subtract
    assign trial = {rem_i, nq_i[QW-1]};
    assign diff  = trial - {1'b0, den_i};
    assign ge    = trial >= {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        nq_r[s]   <= {nq_i[QW-2:0], ge};
        den_r[s]  <= den_i;
        side_r[s] <= side_i;
      end
    end
  end

  assign out_valid  = v_r[QW-1];
  assign out_quo    = nq_r[QW-1];
  assign out_rem_nz = |rem_r[QW-1];
  assign out_side   = side_r[QW-1];

endmodule
`default_nettype wire

[rtl/cubic_hermite_joint_interpolator.sv]
// Cubic Hermite joint interpolator, fully pipelined.
// Throughput one transaction per cycle, except while a stalled output holds the pipeline.
// Most of the pipeline depth is in the two bit-per-stage dividers (31 stages for u, 50 for the slope term).
// A stalled output that holds a valid result freezes the whole pipeline; nothing is dropped or repeated.
// Synchronous active-low reset clears every stage valid bit; payload is not reset.
// Depends on chi_pkg and chi_pipe_div.
`default_nettype none
module cubic_hermite_joint_interpolator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_start_position,
  input  wire logic [31:0] in_start_velocity,
  input  wire logic [31:0] in_end_position,
  input  wire logic [31:0] in_end_velocity,
  input  wire logic [30:0] in_segment_duration,
  input  wire logic [31:0] in_query_time,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [30:0]      out_clamped_time,
  output logic [31:0]      out_interp_position,
  output logic [31:0]      out_interp_velocity,
  output logic             out_zero_duration_error
);

  localparam int DW = chi_pkg::DATA_W;
  localparam int TW = chi_pkg::TIME_W;
  localparam int FW = chi_pkg::FRAC_W;
  localparam int UW = chi_pkg::U_W;
  localparam int SW = chi_pkg::SUM_W;
  localparam int VQ = chi_pkg::VDIV_QUO_W;
  localparam int VN = chi_pkg::VDIV_NUM_W;
  localparam int VD = chi_pkg::VDIV_DEN_W;
  localparam int S1_W = 4 * DW + 2 * TW + 1;
  localparam int S2_W = TW + DW + 35 + 1 + DW + 1;

  logic en;
  logic out_valid_r;

  // Advance everything unless a finished result is held
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // ---------------- Stage 0: capture and clamp ----------------
  logic          v0_r;
  logic [DW-1:0] p0_r, ve0_r, p1_r, ve1_r;
  logic [TW-1:0] dur_r, tc_r;
  logic          zero_r;
  logic [TW-1:0] tc_nxt;

  always_comb begin
    if (in_query_time[31]) begin
      tc_nxt = '0;
    end else if (in_query_time[30:0] > in_segment_duration) begin
      tc_nxt = in_segment_duration;
    end else begin
      tc_nxt = in_query_time[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r   <= in_start_position;
      ve0_r  <= in_start_velocity;
      p1_r   <= in_end_position;
      ve1_r  <= in_end_velocity;
      dur_r  <= in_segment_duration;
      tc_r   <= tc_nxt;
      zero_r <= (in_segment_duration == '0);
    end
  end

  // ---------------- Normalized time divider ----------------
  logic            d1_v;
  logic [UW-1:0]   d1_u;
  logic            d1_rnz;
  logic [S1_W-1:0] d1_side;
  logic [DW-1:0]   d1_p0, d1_ve0, d1_p1, d1_ve1;
  logic [TW-1:0]   d1_dur, d1_tc;
  logic            d1_zero;

  chi_pipe_div #(
    .NW(chi_pkg::NDIV_NUM_W),
    .DW(chi_pkg::NDIV_DEN_W),
    .QW(chi_pkg::NDIV_QUO_W),
    .SW(S1_W)
  ) u_ndiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v0_r),
    .in_num    ({tc_r, {FW{1'b0}}}),
    .in_den    (dur_r),
    .in_side   ({p0_r, ve0_r, p1_r, ve1_r, dur_r, tc_r, zero_r}),
    .out_valid (d1_v),
    .out_quo   (d1_u),
    .out_rem_nz(d1_rnz),
    .out_side  (d1_side)
  );

  assign {d1_p0, d1_ve0, d1_p1, d1_ve1, d1_dur, d1_tc, d1_zero} = d1_side;

  // ---------------- Stage A: u squared ----------------
  logic            va_r;
  logic [2*UW-1:0] usq_a_r;
  logic [UW-1:0]   u_a_r;
  logic [DW-1:0]   p0_a_r, ve0_a_r, p1_a_r, ve1_a_r;
  logic [TW-1:0]   dur_a_r, tc_a_r;
  logic            zero_a_r;

  // ---------------- Stage B: u2 ----------------
  logic            vb_r;
  logic [UW-1:0]   u2_b_r, u_b_r;
  logic [DW-1:0]   p0_b_r, ve0_b_r, p1_b_r, ve1_b_r;
  logic [TW-1:0]   dur_b_r, tc_b_r;
  logic            zero_b_r;

  // ---------------- Stage C: u2 * u ----------------
  logic            vc_r;
  logic [2*UW-1:0] u3p_c_r;
  logic [UW-1:0]   u2_c_r, u_c_r;
  logic [DW-1:0]   p0_c_r, ve0_c_r, p1_c_r, ve1_c_r;
  logic [TW-1:0]   dur_c_r, tc_c_r;
  logic            zero_c_r;

  // ---------------- Stage D: basis weights ----------------
  logic                 vd_r;
  logic signed [DW-1:0] h00_d_r, h10_d_r, h01_d_r, h11_d_r, k_d_r, g0_d_r, g1_d_r;
  logic signed [DW:0]   dp_d_r;
  logic [DW-1:0]        p0_d_r, ve0_d_r, p1_d_r, ve1_d_r;
  logic [TW-1:0]        dur_d_r, tc_d_r;
  logic                 zero_d_r;

  logic signed [33:0] ue, u2e, u3e;
  assign ue  = signed'({3'b0, u_c_r});
  assign u2e = signed'({3'b0, u2_c_r});
  assign u3e = signed'({3'b0, u3p_c_r[FW +: UW]});

  // ---------------- Stage E: products ----------------
  logic                   ve_r;
  logic signed [2*DW-1:0] m00_e_r, m01_e_r, m10_e_r, m11_e_r, mg0_e_r, mg1_e_r;
  logic signed [2*DW:0]   mk_e_r;
  logic [DW-1:0]          p1_e_r, ve1_e_r;
  logic [TW-1:0]          dur_e_r, tc_e_r;
  logic                   zero_e_r;

  // ---------------- Stage F: scale down ----------------
  logic               vf_r;
  logic signed [33:0] t00_f_r, t01_f_r, a10_f_r, a11_f_r, tg0_f_r, tg1_f_r;
  logic [VN-1:0]      mkmag_f_r;
  logic               neg_f_r;
  logic [DW-1:0]      p1_f_r, ve1_f_r;
  logic [TW-1:0]      dur_f_r, tc_f_r;
  logic               zero_f_r;

  // ---------------- Stage G: velocity terms times T ----------------
  logic               vg_r;
  logic signed [65:0] n10_g_r, n11_g_r;
  logic signed [33:0] t00_g_r, t01_g_r;
  logic signed [34:0] gsum_g_r;
  logic [VN-1:0]      mkmag_g_r;
  logic               neg_g_r;
  logic [DW-1:0]      p1_g_r, ve1_g_r;
  logic [TW-1:0]      dur_g_r, tc_g_r;
  logic               zero_g_r;

  // ---------------- Stage H: position sum ----------------
  logic               vh_r;
  logic [DW-1:0]      pos_h_r;
  logic signed [34:0] gsum_h_r;
  logic [VN-1:0]      mkmag_h_r;
  logic               neg_h_r;
  logic [DW-1:0]      ve1_h_r;
  logic [TW-1:0]      dur_h_r, tc_h_r;
  logic               zero_h_r;
  logic signed [SW-1:0] pos_sum;

  assign pos_sum = SW'(t00_g_r) + SW'(t01_g_r) + SW'(n10_g_r >>> 16) + SW'(n11_g_r >>> 16);

  // Valid bits for the middle stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      vg_r <= 1'b0;
      vh_r <= 1'b0;
    end else if (en) begin
      va_r <= d1_v;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      vf_r <= ve_r;
      vg_r <= vf_r;
      vh_r <= vg_r;
    end
  end

  // Payload of the middle stages
  always_ff @(posedge clk) begin
    if (en) begin
      // A: square u
      usq_a_r  <= d1_u * d1_u;
      u_a_r    <= d1_u;
      p0_a_r   <= d1_p0;
      ve0_a_r  <= d1_ve0;
      p1_a_r   <= d1_p1;
      ve1_a_r  <= d1_ve1;
      dur_a_r  <= d1_dur;
      tc_a_r   <= d1_tc;
      zero_a_r <= d1_zero;
      // B: take u2
      u2_b_r   <= usq_a_r[FW +: UW];
      u_b_r    <= u_a_r;
      p0_b_r   <= p0_a_r;
      ve0_b_r  <= ve0_a_r;
      p1_b_r   <= p1_a_r;
      ve1_b_r  <= ve1_a_r;
      dur_b_r  <= dur_a_r;
      tc_b_r   <= tc_a_r;
      zero_b_r <= zero_a_r;
      // C: cube
      u3p_c_r  <= u2_b_r * u_b_r;
      u2_c_r   <= u2_b_r;
      u_c_r    <= u_b_r;
      p0_c_r   <= p0_b_r;
      ve0_c_r  <= ve0_b_r;
      p1_c_r   <= p1_b_r;
      ve1_c_r  <= ve1_b_r;
      dur_c_r  <= dur_b_r;
      tc_c_r   <= tc_b_r;
      zero_c_r <= zero_b_r;
      // D: Hermite basis and its derivative
      h00_d_r  <= DW'(2 * u3e - 3 * u2e + chi_pkg::ONE_Q30);
      h10_d_r  <= DW'(u3e - 2 * u2e + ue);
      h01_d_r  <= DW'(3 * u2e - 2 * u3e);
      h11_d_r  <= DW'(u3e - u2e);
      k_d_r    <= DW'(6 * (ue - u2e));
      g0_d_r   <= DW'(3 * u2e - 4 * ue + chi_pkg::ONE_Q30);
      g1_d_r   <= DW'(3 * u2e - 2 * ue);
      dp_d_r   <= (DW+1)'($signed(p1_c_r)) - (DW+1)'($signed(p0_c_r));
      p0_d_r   <= p0_c_r;
      ve0_d_r  <= ve0_c_r;
      p1_d_r   <= p1_c_r;
      ve1_d_r  <= ve1_c_r;
      dur_d_r  <= dur_c_r;
      tc_d_r   <= tc_c_r;
      zero_d_r <= zero_c_r;
      // E: weight the end values
      m00_e_r  <= h00_d_r * $signed(p0_d_r);
      m01_e_r  <= h01_d_r * $signed(p1_d_r);
      m10_e_r  <= h10_d_r * $signed(ve0_d_r);
      m11_e_r  <= h11_d_r * $signed(ve1_d_r);
      mg0_e_r  <= g0_d_r * $signed(ve0_d_r);
      mg1_e_r  <= g1_d_r * $signed(ve1_d_r);
      mk_e_r   <= k_d_r * dp_d_r;
      p1_e_r   <= p1_d_r;
      ve1_e_r  <= ve1_d_r;
      dur_e_r  <= dur_d_r;
      tc_e_r   <= tc_d_r;
      zero_e_r <= zero_d_r;
      // F: drop Q30 fraction, take slope magnitude
      t00_f_r  <= 34'(m00_e_r >>> FW);
      t01_f_r  <= 34'(m01_e_r >>> FW);
      a10_f_r  <= 34'(m10_e_r >>> FW);
      a11_f_r  <= 34'(m11_e_r >>> FW);
      tg0_f_r  <= 34'(mg0_e_r >>> FW);
      tg1_f_r  <= 34'(mg1_e_r >>> FW);
      neg_f_r  <= mk_e_r[2*DW];
      mkmag_f_r <= mk_e_r[2*DW] ? VN'(-mk_e_r) : VN'(mk_e_r);
      p1_f_r   <= p1_e_r;
      ve1_f_r  <= ve1_e_r;
      dur_f_r  <= dur_e_r;
      tc_f_r   <= tc_e_r;
      zero_f_r <= zero_e_r;
      // G: scale velocity terms by T
      n10_g_r  <= a10_f_r * $signed({1'b0, dur_f_r});
      n11_g_r  <= a11_f_r * $signed({1'b0, dur_f_r});
      t00_g_r  <= t00_f_r;
      t01_g_r  <= t01_f_r;
      gsum_g_r <= 35'(tg0_f_r) + 35'(tg1_f_r);
      mkmag_g_r <= mkmag_f_r;
      neg_g_r  <= neg_f_r;
      p1_g_r   <= p1_f_r;
      ve1_g_r  <= ve1_f_r;
      dur_g_r  <= dur_f_r;
      tc_g_r   <= tc_f_r;
      zero_g_r <= zero_f_r;
      // H: sum and clip position, substitute end value for zero duration
      pos_h_r  <= zero_g_r ? p1_g_r : chi_pkg::sat32(pos_sum);
      gsum_h_r <= gsum_g_r;
      mkmag_h_r <= mkmag_g_r;
      neg_h_r  <= neg_g_r;
      ve1_h_r  <= ve1_g_r;
      dur_h_r  <= dur_g_r;
      tc_h_r   <= zero_g_r ? '0 : tc_g_r;
      zero_h_r <= zero_g_r;
    end
  end

  // ---------------- Slope divider ----------------
  logic            d2_v;
  logic [VQ-1:0]   d2_q;
  logic            d2_rnz;
  logic [S2_W-1:0] d2_side;
  logic [TW-1:0]   d2_tc;
  logic [DW-1:0]   d2_pos, d2_ve1;
  logic signed [34:0] d2_gsum;
  logic            d2_neg, d2_zero;

  chi_pipe_div #(
    .NW(VN),
    .DW(VD),
    .QW(VQ),
    .SW(S2_W)
  ) u_vdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vh_r),
    .in_num    (mkmag_h_r),
    .in_den    ({dur_h_r, 14'b0}),
    .in_side   ({tc_h_r, pos_h_r, gsum_h_r, neg_h_r, ve1_h_r, zero_h_r}),
    .out_valid (d2_v),
    .out_quo   (d2_q),
    .out_rem_nz(d2_rnz),
    .out_side  (d2_side)
  );

  assign {d2_tc, d2_pos, d2_gsum, d2_neg, d2_ve1, d2_zero} = d2_side;

  // Floor the signed quotient and add the velocity terms
  logic signed [VQ+1:0] vq;
  logic signed [SW-1:0] vel_sum;

  always_comb begin
    if (d2_neg) begin
      vq = -($signed({2'b0, d2_q}) + $signed({{(VQ+1){1'b0}}, d2_rnz}));
    end else begin
      vq = $signed({2'b0, d2_q});
    end
    vel_sum = SW'(vq) + SW'(d2_gsum);
  end

  // ---------------- Output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_clamped_time        <= d2_tc;
      out_interp_position     <= d2_pos;
      out_interp_velocity     <= d2_zero ? d2_ve1 : chi_pkg::sat32(vel_sum);
      out_zero_duration_error <= d2_zero;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for the cubic Hermite joint interpolator: random and directed segments.
// Predicts each result in 64-bit integer math; depends on the RTL top level only.
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic signed [31:0] p0;
    logic signed [31:0] v0;
    logic signed [31:0] p1;
    logic signed [31:0] v1;
    logic [30:0]        dur;
    logic signed [31:0] qt;
  } segment_t;

  typedef struct {
    logic [30:0] tc;
    logic [31:0] pos;
    logic [31:0] vel;
    logic        zerr;
  } sample_t;

  localparam int HOLD_START = 400;
  localparam int HOLD_LEN   = 300;
  localparam int CALM_START = 1200;
  localparam int CALM_LEN   = 400;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_start_position;
  logic [31:0] in_start_velocity;
  logic [31:0] in_end_position;
  logic [31:0] in_end_velocity;
  logic [30:0] in_segment_duration;
  logic [31:0] in_query_time;
  logic        out_valid;
  logic        out_stall;
  logic [30:0] out_clamped_time;
  logic [31:0] out_interp_position;
  logic [31:0] out_interp_velocity;
  logic        out_zero_duration_error;

  segment_t pending_segments[$];
  sample_t  expected_samples[$];
  int       mismatch_count;
  int       cycle_count;
  bit       stimulus_loaded;

  cubic_hermite_joint_interpolator uut (.*);

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint sat_q16(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Evaluate the Hermite curve at the clamped time
  function automatic sample_t predict_hermite(segment_t s);
    longint p0, v0, p1, v1, dur, tc, u, u2, u3;
    longint h00, h10, h01, h11, k, g0, g1, pos, vel, num, den, quo;
    sample_t r;
    p0 = s.p0; v0 = s.v0; p1 = s.p1; v1 = s.v1;
    dur = longint'({33'd0, s.dur});
    if (dur == 0) begin
      r.tc = '0; r.pos = s.p1; r.vel = s.v1; r.zerr = 1'b1;
      return r;
    end
    tc = s.qt;
    if (tc < 0) tc = 0;
    else if (tc > dur) tc = dur;
    u  = (tc <<< 30) / dur;
    u2 = (u * u) >>> 30;
    u3 = (u2 * u) >>> 30;
    h00 = 2 * u3 - 3 * u2 + (64'sd1 <<< 30);
    h10 = u3 - 2 * u2 + u;
    h01 = 3 * u2 - 2 * u3;
    h11 = u3 - u2;
    pos = ((h00 * p0) >>> 30) + ((h01 * p1) >>> 30)
        + ((((h10 * v0) >>> 30) * dur) >>> 16)
        + ((((h11 * v1) >>> 30) * dur) >>> 16);
    k  = 6 * (u - u2);
    g0 = 3 * u2 - 4 * u + (64'sd1 <<< 30);
    g1 = 3 * u2 - 2 * u;
    num = k * (p1 - p0);
    den = dur <<< 14;
    quo = num / den;
    if ((num % den) != 0 && num < 0) quo = quo - 1;
    vel = quo + ((g0 * v0) >>> 30) + ((g1 * v1) >>> 30);
    r.tc = tc[30:0];
    r.pos = 32'(sat_q16(pos));
    r.vel = 32'(sat_q16(vel));
    r.zerr = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  function automatic bit idle_now();
    if (cycle_count >= CALM_START && cycle_count < CALM_START + CALM_LEN) return 1'b0;
    return $urandom_range(99) < 36;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(2))
      0: return $urandom();
      1: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
      default: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
    endcase
  endfunction

  function automatic segment_t rand_segment();
    segment_t s;
    logic [30:0] d;
    s.p0 = rand_value(); s.v0 = rand_value();
    s.p1 = rand_value(); s.v1 = rand_value();
    case ($urandom_range(7))
      0: d = 31'($urandom());
      1: d = '0;
      2: d = 31'($urandom_range(1, 16));
      default: d = 31'($urandom_range(1, 1 << 20));
    endcase
    s.dur = d;
    case ($urandom_range(5))
      0: s.qt = $urandom();
      1: s.qt = -$signed({1'b0, 31'($urandom_range(1 << 18))});
      2: s.qt = {1'b0, d} + $urandom_range(1 << 18);
      default: s.qt = {1'b0, 31'($urandom_range(d))};
    endcase
    return s;
  endfunction

  // Fill the stimulus queue: directed corner cases, then random segments
  initial begin
    segment_t s;
    s = '{32'sd65536, 32'sd0, 32'sd131072, 32'sd0, 31'd65536, 32'sd0};
    pending_segments.push_back(s);
    s.qt = 32'sd32768;  pending_segments.push_back(s);
    s.qt = 32'sd65536;  pending_segments.push_back(s);
    s.qt = -32'sd5;     pending_segments.push_back(s);
    s.qt = 32'sh7FFF_FFFF; pending_segments.push_back(s);
    s.qt = 32'sh8000_0000; pending_segments.push_back(s);
    s.dur = '0;         pending_segments.push_back(s);
    s = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          31'h7FFF_FFFF, 32'sh4000_0000};
    pending_segments.push_back(s);
    s = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          31'h7FFF_FFFF, 32'sh2000_0000};
    pending_segments.push_back(s);
    s = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
          31'd1, 32'sd0};
    pending_segments.push_back(s);
    s.qt = 32'sd1;      pending_segments.push_back(s);
    s = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
          31'd3, 32'sd1};
    pending_segments.push_back(s);
    s = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
          31'd65536, 32'sd21845};
    pending_segments.push_back(s);
    s = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
          31'd0, 32'sh8000_0000};
    pending_segments.push_back(s);
    s = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'h7FFF_FFFF, 32'sh7FFF_FFFF};
    pending_segments.push_back(s);
    repeat (500) pending_segments.push_back(rand_segment());
    stimulus_loaded = 1'b1;
  end

  // Reset and cycle counter
  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Driver: predict on acceptance, then advance or idle
  always @(posedge clk) begin
    segment_t s;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_samples.push_back(predict_hermite('{in_start_position, in_start_velocity,
            in_end_position, in_end_velocity, in_segment_duration, in_query_time}));
      end
      if (pending_segments.size() > 0 && !idle_now()) begin
        s = pending_segments.pop_front();
        in_valid            <= 1'b1;
        in_start_position   <= s.p0;
        in_start_velocity   <= s.v0;
        in_end_position     <= s.p1;
        in_end_velocity     <= s.v1;
        in_segment_duration <= s.dur;
        in_query_time       <= s.qt;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random, with one long hold-off to fill the pipeline
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (cycle_count >= HOLD_START && cycle_count < HOLD_START + HOLD_LEN) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_now();
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected result", out_interp_position, '0);
      end else begin
        want = expected_samples.pop_front();
        if (out_clamped_time !== want.tc)
          report_mismatch("clamped_time", {1'b0, out_clamped_time}, {1'b0, want.tc});
        if (out_interp_position !== want.pos)
          report_mismatch("interp_position", out_interp_position, want.pos);
        if (out_interp_velocity !== want.vel)
          report_mismatch("interp_velocity", out_interp_velocity, want.vel);
        if (out_zero_duration_error !== want.zerr)
          report_mismatch("zero_duration_error", {31'd0, out_zero_duration_error},
                          {31'd0, want.zerr});
      end
    end
  end

  // Drain and finish: wait until every transaction is sent and every result checked
  initial begin
    mismatch_count = 0;
    cycle_count = 0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    in_start_position = '0;
    in_start_velocity = '0;
    in_end_position = '0;
    in_end_velocity = '0;
    in_segment_duration = '0;
    in_query_time = '0;
    wait (stimulus_loaded && rst_n);
    do begin
      @(posedge clk);
      #1;
    end while (pending_segments.size() != 0 || in_valid || expected_samples.size() != 0);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && expected_samples.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Timeout
  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[sim.f]
rtl/chi_pkg.sv
rtl/chi_pipe_div.sv
rtl/cubic_hermite_joint_interpolator.sv
bench/testbench.sv
